[rtl/adsr_eg_pkg.sv]
// ----------------------------------------------------------------------------
// adsr_eg_pkg
// Shared constants, codes and types of the ADSR envelope generator.
// ----------------------------------------------------------------------------
`default_nettype none

package adsr_eg_pkg;

  // Default datapath widths
  localparam int LEVEL_BITS_DEF = 16;
  localparam int ACC_BITS_DEF   = 32;

  // Fixed field widths
  localparam int OP_BITS      = 2;
  localparam int PEAK_BITS    = 16;
  localparam int ENV_BITS     = 16;
  localparam int PHASE_BITS   = 3;
  localparam int STEP_BITS    = 32;
  localparam int SUSTAIN_BITS = 16;

  // Configuration port
  localparam int CFG_DATA_BITS = 32;
  localparam int CFG_ADDR_BITS = 5;
  localparam int REG_IDX_BITS  = 3;

  localparam logic [REG_IDX_BITS-1:0] REG_ATTACK_STEP  = 3'd0;
  localparam logic [REG_IDX_BITS-1:0] REG_DECAY_STEP   = 3'd1;
  localparam logic [REG_IDX_BITS-1:0] REG_RELEASE_STEP = 3'd2;
  localparam logic [REG_IDX_BITS-1:0] REG_SUSTAIN      = 3'd3;
  localparam logic [REG_IDX_BITS-1:0] REG_CUTOFF_SEL   = 3'd4;

  // Command codes
  localparam logic [OP_BITS-1:0] OP_TICK     = 2'd0;
  localparam logic [OP_BITS-1:0] OP_NOTE_ON  = 2'd1;
  localparam logic [OP_BITS-1:0] OP_NOTE_OFF = 2'd2;

  // Envelope stages
  localparam logic [PHASE_BITS-1:0] PH_IDLE    = 3'd0;
  localparam logic [PHASE_BITS-1:0] PH_ATTACK  = 3'd1;
  localparam logic [PHASE_BITS-1:0] PH_DECAY   = 3'd2;
  localparam logic [PHASE_BITS-1:0] PH_SUSTAIN = 3'd3;
  localparam logic [PHASE_BITS-1:0] PH_RELEASE = 3'd4;
  localparam logic [PHASE_BITS-1:0] PH_CUTOFF  = 3'd5;

  typedef struct packed {
    logic [STEP_BITS-1:0]    attack_step;
    logic [STEP_BITS-1:0]    decay_step;
    logic [STEP_BITS-1:0]    release_step;
    logic [SUSTAIN_BITS-1:0] sustain_fraction;
    logic                    cutoff_uses_decay;
  } cfg_t;

  typedef struct packed {
    logic [PHASE_BITS-1:0] phase;
    logic                  pending;
  } ctrl_t;

endpackage

`default_nettype wire

[rtl/adsr_eg_if.sv]
// ----------------------------------------------------------------------------
// adsr_eg_if
// Valid/ready channels: command words in, envelope sample words out.
// ----------------------------------------------------------------------------
`default_nettype none

interface adsr_eg_cmd_if;
  import adsr_eg_pkg::*;

  logic                 valid;
  logic                 ready;
  logic [OP_BITS-1:0]   op;
  logic [PEAK_BITS-1:0] peak_level;

  modport source (output valid, output op, output peak_level, input ready);
  modport sink   (input valid, input op, input peak_level, output ready);
endinterface

interface adsr_eg_sample_if;
  import adsr_eg_pkg::*;

  logic                  valid;
  logic                  ready;
  logic [ENV_BITS-1:0]   envelope;
  logic [PHASE_BITS-1:0] phase;

  modport source (output valid, output envelope, output phase, input ready);
  modport sink   (input valid, input envelope, input phase, output ready);
endinterface

`default_nettype wire

[rtl/adsr_envelope_generator_unit.sv]
// ----------------------------------------------------------------------------
// adsr_envelope_generator_unit
// ADSR envelope generator: one command word in, one envelope sample word out.
// ----------------------------------------------------------------------------
//
//   channel  | dir | handshake     | word
//   ---------+-----+---------------+------------------------------------------
//   cmd      | in  | valid/ready   | op (tick, note on, note off), peak_level
//   sample   | out | valid/ready   | envelope (Q0.16), phase (stage after it)
//   apb      | in  | psel/penable  | step, sustain and cut-off registers
//
// Throughput is one word per clock while sample ready holds; an accepted word
// passes the input and result registers to sample valid. The rate comes from
// the combinational envelope update: a step-by-level multiply, add and compare.
// Reset is synchronous; it returns the stage to idle, the accumulator to zero
// and the note level to full scale, with no clearing pass.
// A stalled sample word holds in the result register while one more command
// word waits in the input register; cmd ready drops only when both are full.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_envelope_generator_unit #(
  parameter int LEVEL_BITS = adsr_eg_pkg::LEVEL_BITS_DEF,
  parameter int ACC_BITS   = adsr_eg_pkg::ACC_BITS_DEF
) (
  input  logic                                  clk,
  input  logic                                  rst,
  // configuration port
  input  logic                                  psel,
  input  logic                                  penable,
  input  logic                                  pwrite,
  input  logic [adsr_eg_pkg::CFG_ADDR_BITS-1:0] paddr,
  input  logic [adsr_eg_pkg::CFG_DATA_BITS-1:0] pwdata,
  output logic [adsr_eg_pkg::CFG_DATA_BITS-1:0] prdata,
  output logic                                  pready,
  // streams
  adsr_eg_cmd_if.sink                           cmd,
  adsr_eg_sample_if.source                      sample
);
  import adsr_eg_pkg::*;

  // configuration
  cfg_t                     cfg;
  logic [REG_IDX_BITS-1:0]  reg_idx;
  logic                     cfg_wr;

  // input register
  logic                     cmd_held;
  logic [OP_BITS-1:0]       op_q;
  logic [PEAK_BITS-1:0]     peak_q;

  // envelope state
  ctrl_t                    ctrl;
  ctrl_t                    ctrl_next;
  logic [ACC_BITS-1:0]      acc;
  logic [ACC_BITS-1:0]      acc_next;
  logic [LEVEL_BITS-1:0]    level;
  logic [LEVEL_BITS-1:0]    level_next;

  // result register
  logic                     out_valid;
  logic [ENV_BITS-1:0]      env_q;
  logic [PHASE_BITS-1:0]    phase_q;

  logic                     advance;
  logic [LEVEL_BITS+ACC_BITS-1:0] lvl_wide;
  logic [ACC_BITS-1:0]      lvl_acc;

  // ---------------------------------------------------------------- APB ----
  assign pready  = 1'b1;
  assign reg_idx = paddr[CFG_ADDR_BITS-1 -: REG_IDX_BITS];
  assign cfg_wr  = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg <= '0;
    end else if (cfg_wr) begin
      unique case (reg_idx)
        REG_ATTACK_STEP:  cfg.attack_step       <= pwdata;
        REG_DECAY_STEP:   cfg.decay_step        <= pwdata;
        REG_RELEASE_STEP: cfg.release_step      <= pwdata;
        REG_SUSTAIN:      cfg.sustain_fraction  <= pwdata[SUSTAIN_BITS-1:0];
        REG_CUTOFF_SEL:   cfg.cutoff_uses_decay <= pwdata[0];
        default: begin
          // unmapped: drop the write
        end
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ATTACK_STEP:  prdata = cfg.attack_step;
      REG_DECAY_STEP:   prdata = cfg.decay_step;
      REG_RELEASE_STEP: prdata = cfg.release_step;
      REG_SUSTAIN:      prdata = {{(CFG_DATA_BITS-SUSTAIN_BITS){1'b0}}, cfg.sustain_fraction};
      REG_CUTOFF_SEL:   prdata = {{(CFG_DATA_BITS-1){1'b0}}, cfg.cutoff_uses_decay};
      default:          prdata = '0;
    endcase
  end

  // ------------------------------------------------------ flow control ----
  // Advance the held command whenever the result register is free or drains.
  assign advance   = cmd_held && (!out_valid || sample.ready);
  assign cmd.ready = !cmd_held || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      cmd_held <= 1'b0;
    end else if (cmd.valid && cmd.ready) begin
      cmd_held <= 1'b1;
    end else if (advance) begin
      cmd_held <= 1'b0;
    end
  end

  // Capture the command payload on accept
  always_ff @(posedge clk) begin
    if (cmd.valid && cmd.ready) begin
      op_q   <= cmd.op;
      peak_q <= cmd.peak_level;
    end
  end

  // ----------------------------------------------------- envelope step ----
  adsr_eg_step #(
    .LEVEL_BITS (LEVEL_BITS),
    .ACC_BITS   (ACC_BITS)
  ) u_step (
    .cfg        (cfg),
    .ctrl       (ctrl),
    .acc        (acc),
    .level      (level),
    .op         (op_q),
    .peak_level (peak_q),
    .ctrl_next  (ctrl_next),
    .acc_next   (acc_next),
    .level_next (level_next)
  );

  // Commit the stage, accumulator and note level once per advanced word
  always_ff @(posedge clk) begin
    if (rst) begin
      ctrl.phase   <= PH_IDLE;
      ctrl.pending <= 1'b0;
      acc          <= '0;
      level        <= '1;
    end else if (advance) begin
      ctrl  <= ctrl_next;
      acc   <= acc_next;
      level <= level_next;
    end
  end

  // -------------------------------------------------------- result reg ----
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (sample.ready) begin
      out_valid <= 1'b0;
    end
  end

  // Envelope word is the top bits of the accumulator
  always_ff @(posedge clk) begin
    if (advance) begin
      env_q   <= acc_next[ACC_BITS-1 -: ENV_BITS];
      phase_q <= ctrl_next.phase;
    end
  end

  assign sample.valid    = out_valid;
  assign sample.envelope = env_q;
  assign sample.phase    = phase_q;

  // -------------------------------------------------------- assertions ----
  assign lvl_wide = {level, {ACC_BITS{1'b0}}};
  assign lvl_acc  = lvl_wide[LEVEL_BITS +: ACC_BITS];

  // Idle means the envelope has fully ramped down
  a_idle_zero: assert property (@(posedge clk) disable iff (rst)
    ctrl.phase == PH_IDLE |-> acc == '0)
    else $error("idle stage with nonzero accumulator");

  // The envelope never rises above the note level
  a_acc_bounded: assert property (@(posedge clk) disable iff (rst)
    acc <= lvl_acc)
    else $error("accumulator above note level");

  // State only moves when a word advances
  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !advance |=> $stable(acc) && $stable(ctrl))
    else $error("envelope state changed without an advance");

  // A taken result with nothing behind it empties the result register
  a_out_drain: assert property (@(posedge clk) disable iff (rst)
    sample.valid && sample.ready && !advance |=> !sample.valid)
    else $error("result repeated after it was taken");

endmodule

`default_nettype wire

[rtl/adsr_eg_step.sv]
// ----------------------------------------------------------------------------
// adsr_eg_step
// One envelope update: command decode, stage change, scaled ramp and clamp.
// ----------------------------------------------------------------------------
`default_nettype none

module adsr_eg_step #(
  parameter int LEVEL_BITS = adsr_eg_pkg::LEVEL_BITS_DEF,
  parameter int ACC_BITS   = adsr_eg_pkg::ACC_BITS_DEF
) (
  input  adsr_eg_pkg::cfg_t                   cfg,
  input  adsr_eg_pkg::ctrl_t                  ctrl,
  input  logic [ACC_BITS-1:0]                 acc,
  input  logic [LEVEL_BITS-1:0]               level,
  input  logic [adsr_eg_pkg::OP_BITS-1:0]     op,
  input  logic [adsr_eg_pkg::PEAK_BITS-1:0]   peak_level,
  output adsr_eg_pkg::ctrl_t                  ctrl_next,
  output logic [ACC_BITS-1:0]                 acc_next,
  output logic [LEVEL_BITS-1:0]               level_next
);
  import adsr_eg_pkg::*;

  localparam int PROD_BITS = STEP_BITS + LEVEL_BITS;
  localparam int SUS_BITS  = SUSTAIN_BITS + LEVEL_BITS;

  logic                          start;
  logic                          pend_set;
  logic [PHASE_BITS-1:0]         phase_mid;
  logic                          pend_mid;
  logic [PEAK_BITS+LEVEL_BITS-1:0] peak_wide;
  logic [STEP_BITS-1:0]          step;
  logic [PROD_BITS-1:0]          prod;
  logic [PROD_BITS+ACC_BITS-1:0] prod_wide;
  logic [SUS_BITS-1:0]           sus_prod;
  logic [SUS_BITS+ACC_BITS-1:0]  sus_wide;
  logic [LEVEL_BITS+ACC_BITS-1:0] lvl_wide;
  logic [ACC_BITS-1:0]           inc;
  logic [ACC_BITS-1:0]           target;
  logic [ACC_BITS-1:0]           lvl_acc;
  logic [ACC_BITS:0]             sum;
  logic [ACC_BITS:0]             thr;

  // A note-on with zero level behaves as a note-off
  assign start     = (op == OP_NOTE_ON) && (peak_level != '0);
  assign pend_set  = ctrl.pending || (!start && (op == OP_NOTE_ON || op == OP_NOTE_OFF));

  // Align peak to the level format (truncate or pad with zeros)
  assign peak_wide  = {peak_level, {LEVEL_BITS{1'b0}}};
  assign level_next = start ? peak_wide[PEAK_BITS +: LEVEL_BITS] : level;

  always_comb begin
    phase_mid = ctrl.phase;
    pend_mid  = pend_set;
    priority if (start) begin
      phase_mid = PH_ATTACK;
    end else if (pend_set) begin
      pend_mid = 1'b0;
      if (ctrl.phase == PH_SUSTAIN || ctrl.phase == PH_RELEASE) begin
        phase_mid = PH_RELEASE;
      end else if (ctrl.phase != PH_IDLE) begin
        phase_mid = PH_CUTOFF;
      end
    end else begin
      // plain tick: hold the stage
      phase_mid = ctrl.phase;
    end
  end

  always_comb begin
    unique case (phase_mid)
      PH_ATTACK:  step = cfg.attack_step;
      PH_DECAY:   step = cfg.decay_step;
      PH_RELEASE: step = cfg.release_step;
      PH_CUTOFF:  step = cfg.cutoff_uses_decay ? cfg.decay_step : cfg.release_step;
      default:    step = '0;
    endcase
  end

  // Scale by the note level and align to the accumulator fraction
  assign prod      = step * level_next;
  assign prod_wide = {prod, {ACC_BITS{1'b0}}};
  assign inc       = prod_wide[PROD_BITS +: ACC_BITS];

  assign sus_prod  = cfg.sustain_fraction * level_next;
  assign sus_wide  = {sus_prod, {ACC_BITS{1'b0}}};
  assign target    = sus_wide[SUS_BITS +: ACC_BITS];

  assign lvl_wide  = {level_next, {ACC_BITS{1'b0}}};
  assign lvl_acc   = lvl_wide[LEVEL_BITS +: ACC_BITS];

  assign sum = {1'b0, acc} + {1'b0, inc};
  assign thr = {1'b0, target} + {1'b0, inc};

  always_comb begin
    acc_next          = acc;
    ctrl_next.phase   = phase_mid;
    ctrl_next.pending = pend_mid;
    unique case (phase_mid)
      PH_ATTACK: begin
        if (sum > {1'b0, lvl_acc}) begin
          acc_next        = lvl_acc;
          ctrl_next.phase = PH_DECAY;
        end else begin
          acc_next = sum[ACC_BITS-1:0];
        end
      end
      PH_DECAY: begin
        if ({1'b0, acc} < thr) begin
          acc_next        = target;
          ctrl_next.phase = PH_SUSTAIN;
        end else begin
          acc_next = acc - inc;
        end
      end
      PH_RELEASE, PH_CUTOFF: begin
        if (inc > acc) begin
          acc_next        = '0;
          ctrl_next.phase = PH_IDLE;
        end else begin
          acc_next = acc - inc;
        end
      end
      default: begin
        acc_next = acc;
      end
    endcase
  end

endmodule

`default_nettype wire
